### hdl/sws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types, codes and widths of the stack with search.
// ----------------------------------------------------------------------------
package sws_pkg;

    localparam int DEPTH_DEFAULT     = 1024;
    localparam int WORD_BITS_DEFAULT = 32;

    localparam int OPERAND_BITS   = 32;
    localparam int ACTION_BITS    = 2;
    localparam int TOP_BITS       = 32;
    localparam int COUNT_BITS     = 11;
    localparam int STATUS_BITS    = 2;
    localparam int OUT_FIELD_BITS = TOP_BITS + 1 + COUNT_BITS + STATUS_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_TOP    = 2'd2,
        ACT_SEARCH = 2'd3
    } act_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic    latch;
        logic    push;
        logic    pop;
        logic    pop_read;
        logic    pop_load;
        logic    scan_start;
        logic    scan_next;
        logic    set_found;
        logic    set_result;
        status_t status_code;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        act_t op;
        logic empty;
        logic full;
        logic fill_ge2;
        logic match;
        logic scan_last;
        logic out_free;
    } stat_t;

endpackage

### hdl/sws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sws_ram #(
    parameter int WIDTH     = 32,
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/sws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_ctrl
// Sequencer: takes one item, runs push, pop, top or search, hands the
// result to the output register.
// ----------------------------------------------------------------------------
module sws_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  sws_pkg::stat_t stat,
    output sws_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_EXEC     = 5'b00010,
        S_POP_WAIT = 5'b00100,
        S_SCAN     = 5'b01000,
        S_FINISH   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.status_code = sws_pkg::ST_OK;
        s_tready        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.set_result = 1'b1;
                state_next     = S_FINISH;
                case (stat.op)
                    sws_pkg::ACT_PUSH: begin
                        if (stat.full) begin
                            cmd.status_code = sws_pkg::ST_FULL;
                        end else begin
                            cmd.push = 1'b1;
                        end
                    end
                    sws_pkg::ACT_POP: begin
                        if (stat.empty) begin
                            cmd.status_code = sws_pkg::ST_EMPTY;
                        end else begin
                            cmd.pop = 1'b1;
                            if (stat.fill_ge2) begin
                                cmd.pop_read = 1'b1;
                                state_next   = S_POP_WAIT;
                            end
                        end
                    end
                    sws_pkg::ACT_TOP: begin
                        if (stat.empty) begin
                            cmd.status_code = sws_pkg::ST_EMPTY;
                        end
                    end
                    default: begin
                        if (!stat.empty) begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                endcase
            end
            S_POP_WAIT: begin
                cmd.pop_load = 1'b1;
                state_next   = S_FINISH;
            end
            S_SCAN: begin
                if (stat.match) begin
                    cmd.set_found = 1'b1;
                    state_next    = S_FINISH;
                end else if (stat.scan_last) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/sws_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_datapath
// Entry RAM, fill level, cached top entry, scan pointer and output register.
// ----------------------------------------------------------------------------
module sws_datapath #(
    parameter int DEPTH     = sws_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = sws_pkg::WORD_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [sws_pkg::OPERAND_BITS-1:0]   s_tdata,
    input  logic [sws_pkg::ACTION_BITS-1:0]    s_tuser,
    input  sws_pkg::cmd_t                      cmd,
    output sws_pkg::stat_t                     stat,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sws_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PAD = sws_pkg::OUT_TDATA_BITS - sws_pkg::OUT_FIELD_BITS;

    sws_pkg::act_t    op_reg;
    logic [WORD_BITS-1:0] operand_reg;
    logic [CW-1:0]    fill_reg;
    logic [CW-1:0]    fill_next;
    logic [WORD_BITS-1:0] top_reg;
    logic [AW-1:0]    scan_addr_reg;
    logic             found_reg;
    sws_pkg::status_t status_reg;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [sws_pkg::OUT_TDATA_BITS-1:0] m_data_reg;

    logic [CW-1:0]        fill_minus2;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic [sws_pkg::TOP_BITS-1:0] top_out;

    assign fill_minus2 = fill_reg - CW'(2);
    assign rd_en       = cmd.pop_read | cmd.scan_start | cmd.scan_next;

    always_comb begin
        rd_addr = scan_addr_reg + AW'(1);
        if (cmd.pop_read) begin
            rd_addr = fill_minus2[AW-1:0];
        end else if (cmd.scan_start) begin
            rd_addr = '0;
        end
    end

    sws_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (cmd.push),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (operand_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        fill_next = fill_reg;
        if (cmd.push) begin
            fill_next = fill_reg + CW'(1);
        end else if (cmd.pop) begin
            fill_next = fill_reg - CW'(1);
        end
    end

    assign m_valid_next = cmd.load_out | (m_valid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg      <= sws_pkg::act_t'(s_tuser);
            operand_reg <= WORD_BITS'(s_tdata);
        end
        if (cmd.push) begin
            top_reg <= operand_reg;
        end else if (cmd.pop_load) begin
            top_reg <= rd_data;
        end
        if (cmd.scan_start) begin
            scan_addr_reg <= '0;
        end else if (cmd.scan_next) begin
            scan_addr_reg <= scan_addr_reg + AW'(1);
        end
        if (cmd.set_result) begin
            status_reg <= cmd.status_code;
            found_reg  <= 1'b0;
        end else if (cmd.set_found) begin
            found_reg <= 1'b1;
        end
        if (cmd.load_out) begin
            m_data_reg <= {{PAD{1'b0}}, status_reg,
                           sws_pkg::COUNT_BITS'(fill_reg), found_reg, top_out};
        end
    end

    assign top_out = (fill_reg == '0) ? '0 : sws_pkg::TOP_BITS'(top_reg);

    assign stat.op        = op_reg;
    assign stat.empty     = (fill_reg == '0);
    assign stat.full      = (fill_reg == CW'(DEPTH));
    assign stat.fill_ge2  = (fill_reg >= CW'(2));
    assign stat.match     = (rd_data == operand_reg);
    assign stat.scan_last = ((CW'(scan_addr_reg) + CW'(1)) == fill_reg);
    assign stat.out_free  = ~m_valid_reg | m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### hdl/stack_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_search
// LIFO stack of signed words with push, pop, read top and membership search.
// ----------------------------------------------------------------------------
// One item at a time. Push, read top, refused operations and a pop that
// empties the stack go from acceptance through EXEC to FINISH, which loads
// the result register once it is free; a pop that leaves a new top passes
// through POP_WAIT as well to fetch it. A search reads the entry RAM's
// single read port one entry a cycle from the bottom, stopping at the first
// match or after the top entry. The next item is taken as soon as the result
// has moved into the output register, even while it waits there. No clearing
// pass after reset: only entries below the fill level are read.
// ----------------------------------------------------------------------------
module stack_with_search #(
    parameter int DEPTH     = sws_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = sws_pkg::WORD_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [31:0] operand_value
    input  logic [sws_pkg::OPERAND_BITS-1:0]   s_tdata,
    // [1:0] action
    input  logic [sws_pkg::ACTION_BITS-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] top_value, [32] found, [43:33] entry_count, [45:44] status
    output logic [sws_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

    sws_pkg::cmd_t  cmd;
    sws_pkg::stat_t stat;

    sws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sws_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> !stat.full)
        else $error("push issued on a full stack");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> !stat.empty)
        else $error("pop issued on an empty stack");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid)
        else $error("result loaded but not presented");
`endif

endmodule
